// ===== sv/servo_pwm_slot_seeker_unit_defines.svh =====
// assertion macros for the servo slot seeker checker
`ifndef SERVO_PWM_SLOT_SEEKER_UNIT_DEFINES_SVH
`define SERVO_PWM_SLOT_SEEKER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define SPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sps_pkg.sv =====
// types and constants of the servo slot seeker
package sps_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_CENTER = 2'd0;
	localparam logic [1:0] REG_FRAME  = 2'd1;
	localparam logic [1:0] REG_SPEED  = 2'd2;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned WIDTH_W = 16;
	localparam int unsigned SPEED_W = 10;
	localparam int unsigned SW_W = 5;

	// register reset values
	localparam logic [WIDTH_W-1:0] CENTER_RST = 16'd3000;
	localparam logic [WIDTH_W-1:0] FRAME_RST  = 16'd40000;
	localparam logic [SPEED_W-1:0] SPEED_RST  = 10'd40;

	typedef struct packed {
		logic [1:0]      command;
		logic [2:0]      destination;
		logic [SW_W-1:0] switches;
	} cmd_item_t;

	typedef struct packed {
		logic               pwm_out;
		logic               power_enable;
		logic               done_res;
		logic [WIDTH_W-1:0] pulse_width;
	} res_item_t;

endpackage

// ===== sv/sps_if.sv =====
// valid/ready channels for commands and results
interface sps_cmd_if import sps_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sps_res_if import sps_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/servo_pwm_slot_seeker_unit.sv =====
// servo slot seeker: pwm generation and limit-switch stop seeking
//
// cmd_ch carries one command per transfer: a timer tick, a start with a
// destination stop, or a switch change event with the sampled switches.
// res_ch returns exactly one result per command: pwm pin level, servo
// power, done flag and the current pulse width, all as they stand after
// that command.
// The apb port holds three registers: centre width (0x0), frame length
// (0x4) and seek speed offset (0x8); write them only while idle.
// A command transfer reaches its result through one input register, then
// the state update and the result register, which are written together.
// Throughput is one command per cycle while res_ch accepts results, set
// by the single step that reads and writes all pwm and seek state at once.
// If res_ch stalls, the result register holds, the input register fills,
// and cmd_ch.ready falls one transfer later; nothing is dropped.
// Reset clears both valid flags and the seek state, restores the register
// defaults, and leaves the block idle with power and pwm low.
module servo_pwm_slot_seeker_unit import sps_pkg::*; #(
	parameter int unsigned NUM_STOPS  = 5,
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	sps_cmd_if.sink           cmd_ch,
	sps_res_if.source         res_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int unsigned TGT_W = $clog2(NUM_STOPS);
	localparam logic [2:0] LAST_STOP = 3'(NUM_STOPS - 1);
	localparam logic [SW_W-1:0] SW_MASK =
		(NUM_STOPS >= SW_W) ? {SW_W{1'b1}} : SW_W'((1 << NUM_STOPS) - 1);
	localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

	// configuration registers
	logic [WIDTH_W-1:0] center_q;
	logic [WIDTH_W-1:0] frame_q;
	logic [SPEED_W-1:0] speed_q;
	logic [1:0]         reg_idx;
	logic               cfg_wr;

	// pipeline and seek state
	logic                  valid_s1;
	cmd_item_t             item_s1;
	logic                  valid_s2;
	res_item_t             res_s2;
	logic                  advance;
	logic [TIMER_BITS-1:0] count_q;
	logic [TIMER_BITS-1:0] compare_q;
	logic                  pin_q;
	logic [WIDTH_W-1:0]    width_q;
	logic                  up_q;
	logic [TGT_W-1:0]      target_q;
	logic                  running_q;
	logic                  arrived_q;

	// next-state values
	logic [TIMER_BITS-1:0] count_d;
	logic [TIMER_BITS-1:0] compare_d;
	logic                  pin_d;
	logic [WIDTH_W-1:0]    width_d;
	logic                  up_d;
	logic [TGT_W-1:0]      target_d;
	logic                  running_d;
	logic                  arrived_d;

	logic [WIDTH_W-1:0]    seek_dn;
	logic [WIDTH_W-1:0]    seek_up;
	logic [WIDTH_W:0]      up_sum;
	logic [WIDTH_W-1:0]    width_cl;
	logic [SW_W-1:0]       sw_m;
	logic                  sw_single;
	logic [2:0]            stop_p;
	logic [2:0]            target_x;

	// saturate a frame-limited value to the timer range
	function automatic logic [TIMER_BITS-1:0] cap_timer(input logic [WIDTH_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		return (v32 > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : v32[TIMER_BITS-1:0];
	endfunction

	// apb access, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			frame_q  <= FRAME_RST;
			speed_q  <= SPEED_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_CENTER: center_q <= pwdata[WIDTH_W-1:0];
				REG_FRAME:  frame_q  <= pwdata[WIDTH_W-1:0];
				REG_SPEED:  speed_q  <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CENTER: prdata = 32'(center_q);
			REG_FRAME:  prdata = 32'(frame_q);
			REG_SPEED:  prdata = 32'(speed_q);
			default:    prdata = '0;
		endcase
	end

	// handshake: input register advances whenever the result slot frees
	assign advance      = !valid_s2 || res_ch.ready;
	assign cmd_ch.ready = !valid_s1 || advance;
	assign res_ch.valid = valid_s2;
	assign res_ch.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			item_s1 <= cmd_ch.data;
		end
	end

	// seek widths, saturated at both ends
	assign up_sum  = {1'b0, center_q} + (WIDTH_W + 1)'(speed_q);
	assign seek_up = up_sum[WIDTH_W] ? {WIDTH_W{1'b1}} : up_sum[WIDTH_W-1:0];
	assign seek_dn = (WIDTH_W'(speed_q) > center_q) ? '0 : center_q - WIDTH_W'(speed_q);

	// width limited to the frame, for compare values
	assign width_cl = (width_q > frame_q) ? frame_q : width_q;

	// switch decode: single switch and its stop index
	assign sw_m      = item_s1.switches & SW_MASK;
	assign sw_single = (sw_m != '0) && ((sw_m & (sw_m - SW_W'(1))) == '0);
	assign target_x  = 3'(target_q);

	always_comb begin
		stop_p = '0;
		for (int i = SW_W - 1; i >= 0; i--) begin
			if (sw_m[i]) begin
				stop_p = 3'(i);
			end
		end
	end

	// state update for the command in the input register
	always_comb begin
		count_d   = count_q;
		compare_d = compare_q;
		pin_d     = pin_q;
		width_d   = width_q;
		up_d      = up_q;
		target_d  = target_q;
		running_d = running_q;
		arrived_d = arrived_q;
		case (item_s1.command)
			CMD_START: begin
				target_d  = (item_s1.destination > LAST_STOP) ?
					TGT_W'(LAST_STOP) : TGT_W'(item_s1.destination);
				up_d      = 1'b0;
				arrived_d = 1'b0;
				running_d = 1'b1;
				pin_d     = 1'b0;
				count_d   = '0;
				compare_d = cap_timer(frame_q - ((center_q > frame_q) ? frame_q : center_q));
				width_d   = seek_dn;
			end
			CMD_TICK: begin
				if (running_q) begin
					if (count_q >= compare_q) begin
						pin_d     = !pin_q;
						count_d   = '0;
						compare_d = !pin_q ? cap_timer(width_cl) :
							cap_timer(frame_q - width_cl);
					end else begin
						count_d = count_q + TIMER_BITS'(1);
					end
				end
			end
			CMD_SWITCH: begin
				if (running_q) begin
					if (!sw_single) begin
						width_d = up_q ? seek_up : seek_dn;
					end else if (target_x < stop_p) begin
						up_d    = 1'b0;
						width_d = seek_dn;
					end else if (target_x > stop_p) begin
						up_d    = 1'b1;
						width_d = seek_up;
					end else begin
						width_d   = center_q;
						running_d = 1'b0;
						pin_d     = 1'b0;
						arrived_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// state registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			compare_q <= '0;
			pin_q     <= 1'b0;
			width_q   <= CENTER_RST;
			up_q      <= 1'b0;
			target_q  <= '0;
			running_q <= 1'b0;
			arrived_q <= 1'b0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				count_q   <= count_d;
				compare_q <= compare_d;
				pin_q     <= pin_d;
				width_q   <= width_d;
				up_q      <= up_d;
				target_q  <= target_d;
				running_q <= running_d;
				arrived_q <= arrived_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2.pwm_out      <= pin_d;
			res_s2.power_enable <= running_d;
			res_s2.done_res     <= arrived_d;
			res_s2.pulse_width  <= width_d;
		end
	end

endmodule

// ===== sv/sps_checker.sv =====
// port-level checks of the servo slot seeker, bound to the top level
`include "servo_pwm_slot_seeker_unit_defines.svh"

module sps_checker import sps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_data
);

	// a stalled result stays offered
	`SPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// a stalled result keeps its payload
	`SPS_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_data), "stalled result changed")

	// done means power is off
	`SPS_ASSERT_SAME(a_done_off, res_valid && res_data.done_res, !res_data.power_enable, "done while powered")

	// the pwm pin only drives while powered
	`SPS_ASSERT_SAME(a_pwm_power, res_valid && res_data.pwm_out, res_data.power_enable, "pwm high without power")

endmodule

bind servo_pwm_slot_seeker_unit sps_checker u_sps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_ch.valid),
	.res_ready (res_ch.ready),
	.res_data  (res_ch.data)
);
